// ===== rtl/cpfsk_modulator_defines.svh =====
// assertion macros for the cpfsk modulator
// define NO_ASSERTIONS to compile them out
`ifndef CPFSK_MODULATOR_DEFINES_SVH
`define CPFSK_MODULATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// antecedent and consequent in the same cycle
`define CPFSK_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpfsk_modulator: same-cycle check failed");

// consequent in the cycle after the antecedent
`define CPFSK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpfsk_modulator: next-cycle check failed");

`else

`define CPFSK_ASSERT_SAME(label, ante, cons)
`define CPFSK_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/cpfsk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cpfsk_pkg;

    // block configuration
    localparam int SAMPLES_PER_SYMBOL = 4;
    localparam int PULSE_SYMBOLS      = 2;
    localparam int PHASE_BITS         = 16;
    localparam int SAMPLE_BITS        = 16;

    // port widths
    localparam int STEP_BITS = 14;
    localparam int OUT_BITS  = 16;
    localparam int ADDR_BITS = 3;
    localparam int DATA_BITS = 32;

    // derived widths
    localparam int CNT_BITS = $clog2(SAMPLES_PER_SYMBOL);
    localparam int HIST_LEN = (PULSE_SYMBOLS > 1) ? PULSE_SYMBOLS - 1 : 1;
    localparam int SUM_BITS = $clog2(PULSE_SYMBOLS + 1) + 1;

    // register map (word index)
    localparam logic [ADDR_BITS-3:0] REG_PHASE_STEP = '0;
    localparam logic [STEP_BITS-1:0] PHASE_STEP_RESET = 14'd2048;

    // pi in Q32
    localparam logic [33:0] PI_Q32 = 34'd13493037704;

    // taylor series, in horner evaluation order (innermost term first)
    localparam int HORNER_STEPS = 8;
    localparam int DIV_BITS     = 9;

    localparam logic [DIV_BITS-1:0] SIN_DIV [HORNER_STEPS] =
        '{9'd272, 9'd210, 9'd156, 9'd110, 9'd72, 9'd42, 9'd20, 9'd6};
    localparam logic [DIV_BITS-1:0] COS_DIV [HORNER_STEPS] =
        '{9'd240, 9'd182, 9'd132, 9'd90, 9'd56, 9'd30, 9'd12, 9'd2};

    // floor(2^32 / divisor), same order
    localparam logic [31:0] SIN_RCP [HORNER_STEPS] =
        '{32'd15790320, 32'd20452225, 32'd27531841, 32'd39045157,
          32'd59652323, 32'd102261126, 32'd214748364, 32'd715827882};
    localparam logic [31:0] COS_RCP [HORNER_STEPS] =
        '{32'd17895697, 32'd23598721, 32'd32537631, 32'd47721858,
          32'd76695844, 32'd143165576, 32'd357913941, 32'd2147483648};

    // one symbol: -1, 0 (none yet) or +1
    typedef logic signed [1:0] sym_t;

    // sideband of a sample moving through the sin/cos pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } smp_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/cpfsk_sincos.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cpfsk_sincos
    import cpfsk_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  smp_ctl_t                   in_ctl,
    input  logic [PHASE_BITS-1:0]      phase,
    output smp_ctl_t                   out_ctl,
    output logic signed [OUT_BITS-1:0] cos_out,
    output logic signed [OUT_BITS-1:0] sin_out
);

    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } quad_t;

    typedef struct packed {
        logic [31:0] x2;
        logic [30:0] x;
        quad_t       quad;
        logic        last;
    } hside_t;

    localparam int          XP_BITS  = PHASE_BITS + 32;
    localparam int          MAG_BITS = SAMPLE_BITS - 1;
    localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
    localparam logic [MAG_BITS-1:0] MAG_MAX = '1;

    // round a Q30 magnitude to the sample scale and saturate
    function automatic logic [MAG_BITS-1:0] to_sample(input logic [31:0] v);
        logic [32:0] sum;
        logic [32:0] u;
        sum = {1'b0, v} + (33'd1 << (30 - SAMPLE_BITS));
        u   = sum >> (31 - SAMPLE_BITS);
        if (u[32:MAG_BITS] != '0)
            return MAG_MAX;
        return u[MAG_BITS-1:0];
    endfunction

    // angle stage: quadrant and Q30 radians of the residual
    logic [PHASE_BITS-3:0] rlow;
    logic [XP_BITS-1:0]    xp_next;
    logic                  q_vld_reg;
    logic                  q_last_reg;
    quad_t                 q_quad_reg;
    logic [30:0]           q_x_reg;

    assign rlow    = phase[PHASE_BITS-3:0];
    assign xp_next = XP_BITS'(rlow) * XP_BITS'(PI_Q32) + (XP_BITS'(1) << PHASE_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_vld_reg <= 1'b0;
        else if (advance)
            q_vld_reg <= in_ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            q_last_reg <= in_ctl.last;
            q_quad_reg <= quad_t'(phase[PHASE_BITS-1 -: 2]);
            q_x_reg    <= xp_next[PHASE_BITS+31:PHASE_BITS+1];
        end
    end

    // horner pipeline: index 0 is fed by the squaring stage
    logic        h_vld_reg   [HORNER_STEPS+1];
    hside_t      h_side_reg  [HORNER_STEPS+1];
    logic [30:0] h_mag_s_reg [HORNER_STEPS+1];
    logic [30:0] h_mag_c_reg [HORNER_STEPS+1];

    // squaring stage
    logic [61:0] sq;

    assign sq = 62'(q_x_reg) * 62'(q_x_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h_vld_reg[0] <= 1'b0;
        else if (advance)
            h_vld_reg[0] <= q_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            h_side_reg[0]  <= '{x2: sq[61:30], x: q_x_reg, quad: q_quad_reg,
                               last: q_last_reg};
            h_mag_s_reg[0] <= Q30_ONE;
            h_mag_c_reg[0] <= Q30_ONE;
        end
    end

    // one horner step per block: product, reciprocal, correction
    for (genvar j = 0; j < HORNER_STEPS; j++)
    begin : g_step
        logic [62:0] a_prod_s;
        logic [62:0] a_prod_c;
        logic        a_vld_reg;
        hside_t      a_side_reg;
        logic [31:0] a_p_s_reg;
        logic [31:0] a_p_c_reg;
        logic [63:0] b_prod_s;
        logic [63:0] b_prod_c;
        logic        b_vld_reg;
        hside_t      b_side_reg;
        logic [31:0] b_p_s_reg;
        logic [31:0] b_p_c_reg;
        logic [31:0] b_q0_s_reg;
        logic [31:0] b_q0_c_reg;
        logic [31:0] c_rem_s;
        logic [31:0] c_rem_c;
        logic [31:0] c_q_s;
        logic [31:0] c_q_c;
        logic [32:0] c_t_s;
        logic [32:0] c_t_c;
        logic [30:0] mag_s_next;
        logic [30:0] mag_c_next;

        // x^2 times running term, back to Q30
        assign a_prod_s = 63'(h_side_reg[j].x2) * 63'(h_mag_s_reg[j]);
        assign a_prod_c = 63'(h_side_reg[j].x2) * 63'(h_mag_c_reg[j]);

        // quotient estimate, low by at most one
        assign b_prod_s = 64'(a_p_s_reg) * 64'(SIN_RCP[j]);
        assign b_prod_c = 64'(a_p_c_reg) * 64'(COS_RCP[j]);

        // fix the quotient, new term = 1 - quotient, clamp at zero
        assign c_rem_s    = b_p_s_reg - 32'(b_q0_s_reg * 32'(SIN_DIV[j]));
        assign c_rem_c    = b_p_c_reg - 32'(b_q0_c_reg * 32'(COS_DIV[j]));
        assign c_q_s      = b_q0_s_reg + 32'(c_rem_s >= 32'(SIN_DIV[j]));
        assign c_q_c      = b_q0_c_reg + 32'(c_rem_c >= 32'(COS_DIV[j]));
        assign c_t_s      = {2'b00, Q30_ONE} - {1'b0, c_q_s};
        assign c_t_c      = {2'b00, Q30_ONE} - {1'b0, c_q_c};
        assign mag_s_next = c_t_s[32] ? '0 : c_t_s[30:0];
        assign mag_c_next = c_t_c[32] ? '0 : c_t_c[30:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_vld_reg      <= 1'b0;
                b_vld_reg      <= 1'b0;
                h_vld_reg[j+1] <= 1'b0;
            end
            else if (advance)
            begin
                a_vld_reg      <= h_vld_reg[j];
                b_vld_reg      <= a_vld_reg;
                h_vld_reg[j+1] <= b_vld_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                a_side_reg       <= h_side_reg[j];
                a_p_s_reg        <= a_prod_s[61:30];
                a_p_c_reg        <= a_prod_c[61:30];
                b_side_reg       <= a_side_reg;
                b_p_s_reg        <= a_p_s_reg;
                b_p_c_reg        <= a_p_c_reg;
                b_q0_s_reg       <= b_prod_s[63:32];
                b_q0_c_reg       <= b_prod_c[63:32];
                h_side_reg[j+1]  <= b_side_reg;
                h_mag_s_reg[j+1] <= mag_s_next;
                h_mag_c_reg[j+1] <= mag_c_next;
            end
        end
    end

    // sine needs one more factor of x
    logic [61:0] f_prod;
    logic        f_vld_reg;
    logic        f_last_reg;
    quad_t       f_quad_reg;
    logic [31:0] f_s_reg;
    logic [30:0] f_c_reg;

    assign f_prod = 62'(h_side_reg[HORNER_STEPS].x) * 62'(h_mag_s_reg[HORNER_STEPS]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_vld_reg <= 1'b0;
        else if (advance)
            f_vld_reg <= h_vld_reg[HORNER_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            f_last_reg <= h_side_reg[HORNER_STEPS].last;
            f_quad_reg <= h_side_reg[HORNER_STEPS].quad;
            f_s_reg    <= f_prod[61:30];
            f_c_reg    <= h_mag_c_reg[HORNER_STEPS];
        end
    end

    // rounding and quadrant fold
    logic [MAG_BITS-1:0]           s_mag;
    logic [MAG_BITS-1:0]           c_mag;
    logic signed [SAMPLE_BITS-1:0] s_pos;
    logic signed [SAMPLE_BITS-1:0] c_pos;
    logic signed [SAMPLE_BITS-1:0] c_sel;
    logic signed [SAMPLE_BITS-1:0] s_sel;
    logic signed [31:0]            c_wide;
    logic signed [31:0]            s_wide;
    logic                          out_vld_reg;
    logic                          out_last_reg;
    logic signed [OUT_BITS-1:0]    out_c_reg;
    logic signed [OUT_BITS-1:0]    out_s_reg;

    assign s_mag = to_sample(f_s_reg);
    assign c_mag = to_sample({1'b0, f_c_reg});
    assign s_pos = signed'({1'b0, s_mag});
    assign c_pos = signed'({1'b0, c_mag});

    always_comb
    begin
        unique case (f_quad_reg)
            QUAD_I:
            begin
                c_sel = c_pos;
                s_sel = s_pos;
            end
            QUAD_II:
            begin
                c_sel = -s_pos;
                s_sel = c_pos;
            end
            QUAD_III:
            begin
                c_sel = -c_pos;
                s_sel = -s_pos;
            end
            QUAD_IV:
            begin
                c_sel = s_pos;
                s_sel = -c_pos;
            end
        endcase
    end

    assign c_wide = 32'(c_sel);
    assign s_wide = 32'(s_sel);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= f_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_last_reg <= f_last_reg;
            out_c_reg    <= c_wide[OUT_BITS-1:0];
            out_s_reg    <= s_wide[OUT_BITS-1:0];
        end
    end

    assign out_ctl = '{valid: out_vld_reg, last: out_last_reg};
    assign cos_out = out_c_reg;
    assign sin_out = out_s_reg;

endmodule

`default_nettype wire

// ===== rtl/cpfsk_modulator.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "cpfsk_modulator_defines.svh"

// Continuous-phase FSK modulator with a rectangular frequency pulse. Each
// request carries one data bit (1 sends +1, 0 sends -1) and yields
// SAMPLES_PER_SYMBOL cos/sin samples in Q1.15, one per cycle unless the
// output stalls, the last one flagged by last_of_symbol; a new bit is taken
// as the last sample of the current bit is issued. The phase generator,
// which issues one sample per cycle unless stalled, feeds a fully pipelined
// sin/cos unit (angle, square, eight three-stage Taylor steps, final sine
// product, rounding) that ends in the output register. A new bit is taken
// while earlier samples are still in flight. The phase advances by phase_step
// times the sum of the current and previous PULSE_SYMBOLS-1 symbols per
// sample; a request with starts_packet set clears the phase and symbol
// history first.
// phase_step lives at byte address 0 of the APB port and should only be
// written while no samples are pending.
module cpfsk_modulator
    import cpfsk_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_BITS-1:0]       paddr,
    input  logic [DATA_BITS-1:0]       pwdata,
    output logic [DATA_BITS-1:0]       prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       data_bit,
    input  logic                       starts_packet,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [OUT_BITS-1:0] in_phase,
    output logic signed [OUT_BITS-1:0] quadrature,
    output logic                       last_of_symbol
);

    // configuration register
    logic [ADDR_BITS-3:0] reg_idx;
    logic                 cfg_write;
    logic [STEP_BITS-1:0] phase_step_reg;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_step_reg <= PHASE_STEP_RESET;
        else if (cfg_write && reg_idx == REG_PHASE_STEP)
            phase_step_reg <= pwdata[STEP_BITS-1:0];
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_PHASE_STEP)
            prdata = DATA_BITS'(phase_step_reg);
    end

    // sample generator state
    logic                  gen_act_reg;
    logic                  gen_act_next;
    logic [CNT_BITS-1:0]   gen_cnt_reg;
    logic [CNT_BITS-1:0]   gen_cnt_next;
    logic [PHASE_BITS-1:0] gen_inc_reg;
    logic [PHASE_BITS-1:0] gen_inc_next;
    logic [PHASE_BITS-1:0] acc_reg;
    logic [PHASE_BITS-1:0] acc_next;
    sym_t                  hist_reg  [HIST_LEN];
    sym_t                  hist_next [HIST_LEN];
    sym_t                  hist_base [HIST_LEN];

    smp_ctl_t              sc_out;
    logic                  advance;
    logic                  cnt_last;
    logic                  emit;
    logic                  in_take;
    sym_t                  sym_new;
    logic signed [SUM_BITS-1:0]          sum_next;
    logic signed [STEP_BITS+SUM_BITS:0]  inc_prod;
    logic [PHASE_BITS-1:0] inc_next;
    logic [PHASE_BITS-1:0] phase_sum;

    // handshake: whole pipeline moves when the output register can take a sample
    assign advance  = !sc_out.valid || out_ready;
    assign cnt_last = gen_cnt_reg == CNT_BITS'(SAMPLES_PER_SYMBOL - 1);
    assign emit     = gen_act_reg && advance;
    assign in_ready = !gen_act_reg || (advance && cnt_last);
    assign in_take  = in_valid && in_ready;

    // symbol mapping and frequency sum
    assign sym_new = data_bit ? 2'sb01 : 2'sb11;

    always_comb
    begin
        for (int i = 0; i < HIST_LEN; i++)
            hist_base[i] = starts_packet ? 2'sb00 : hist_reg[i];
        sum_next = SUM_BITS'(sym_new);
        for (int i = 0; i < PULSE_SYMBOLS - 1; i++)
            sum_next = sum_next + SUM_BITS'(hist_base[i]);
    end

    // per-sample phase step, wrapped to one turn
    assign inc_prod = $signed({1'b0, phase_step_reg}) * sum_next;
    assign inc_next = PHASE_BITS'(inc_prod);

    // history shift on each accepted request
    always_comb
    begin
        hist_next = hist_reg;
        if (in_take)
        begin
            for (int i = HIST_LEN - 1; i > 0; i--)
                hist_next[i] = hist_base[i-1];
            hist_next[0] = sym_new;
        end
    end

    // phase accumulator and generator control
    assign phase_sum = acc_reg + gen_inc_reg;

    always_comb
    begin
        priority if (in_take && starts_packet)
            acc_next = '0;
        else if (emit)
            acc_next = phase_sum;
        else
            acc_next = acc_reg;

        priority if (in_take)
        begin
            gen_act_next = 1'b1;
            gen_cnt_next = '0;
        end
        else if (emit)
        begin
            gen_act_next = !cnt_last;
            gen_cnt_next = gen_cnt_reg + 1'b1;
        end
        else
        begin
            gen_act_next = gen_act_reg;
            gen_cnt_next = gen_cnt_reg;
        end

        gen_inc_next = in_take ? inc_next : gen_inc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_act_reg <= 1'b0;
            gen_cnt_reg <= '0;
            gen_inc_reg <= '0;
            acc_reg     <= '0;
            for (int i = 0; i < HIST_LEN; i++)
                hist_reg[i] <= 2'sb00;
        end
        else
        begin
            gen_act_reg <= gen_act_next;
            gen_cnt_reg <= gen_cnt_next;
            gen_inc_reg <= gen_inc_next;
            acc_reg     <= acc_next;
            hist_reg    <= hist_next;
        end
    end

    // issued sample register
    logic                  smp_vld_reg;
    logic                  smp_last_reg;
    logic [PHASE_BITS-1:0] smp_phase_reg;
    smp_ctl_t              smp_ctl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            smp_vld_reg <= 1'b0;
        else if (advance)
            smp_vld_reg <= gen_act_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            smp_last_reg  <= cnt_last;
            smp_phase_reg <= phase_sum;
        end
    end

    assign smp_ctl = '{valid: smp_vld_reg, last: smp_last_reg};

    // sin/cos pipeline with output register
    cpfsk_sincos u_sincos (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .in_ctl  (smp_ctl),
        .phase   (smp_phase_reg),
        .out_ctl (sc_out),
        .cos_out (in_phase),
        .sin_out (quadrature)
    );

    assign out_valid      = sc_out.valid;
    assign last_of_symbol = sc_out.last;

    // checks
    `CPFSK_ASSERT_NEXT(a_take_starts_run, in_take, gen_act_reg && gen_cnt_reg == '0)
    `CPFSK_ASSERT_NEXT(a_packet_clears_phase, in_take && starts_packet, acc_reg == '0)
    `CPFSK_ASSERT_NEXT(a_run_continues, emit && !cnt_last,
                       gen_act_reg && gen_cnt_reg == $past(gen_cnt_reg) + 1'b1)
    `CPFSK_ASSERT_NEXT(a_stall_holds_phase, !advance && gen_act_reg, $stable(acc_reg) && $stable(gen_cnt_reg))
    `CPFSK_ASSERT_SAME(a_stall_takes_only_idle, out_valid && !out_ready && in_ready, !gen_act_reg)

endmodule

`default_nettype wire
